/* rtl/ini_tok_pkg.sv */
package ini_tok_pkg;

  localparam int unsigned MAX_LINE_DEFAULT = 256;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned OFS_W  = 9;

  localparam logic [KIND_W-1:0] KIND_BLANK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SECTION  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KEYVAL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd4;

  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_HASH      = 8'h23;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_EQUALS    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;

  // c-locale isspace: tab through carriage return, and space
  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* rtl/ini_tok_if.sv */
interface ini_tok_in_if import ini_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  logic              last_byte;

  modport source (output valid, output line_byte, output last_byte, input ready);
  modport sink (input valid, input line_byte, input last_byte, output ready);
endinterface

interface ini_tok_out_if import ini_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] line_kind;
  logic [OFS_W-1:0]  name_start;
  logic [OFS_W-1:0]  name_end;
  logic [OFS_W-1:0]  value_start;
  logic [OFS_W-1:0]  value_end;

  modport source (output valid, output line_kind, output name_start, output name_end,
                  output value_start, output value_end, input ready);
  modport sink (input valid, input line_kind, input name_start, input name_end,
                input value_start, input value_end, output ready);
endinterface

/* rtl/ini_line_tokenizer_core.sv */
// a line's result is registered, valid in the cycle after its last byte is taken
// throughput: one byte per cycle; bytes that are not the last of a line are taken
//   even while a result waits in the output register, a last byte only as it drains
// reset (rst, synchronous): clears the line state and drops any pending result
module ini_line_tokenizer_core import ini_tok_pkg::*; #(
  parameter int unsigned MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ini_tok_in_if.sink    byte_stream,
  ini_tok_out_if.source result
);

  localparam int unsigned POS_W = $clog2(MAX_LINE + 1);

  localparam logic [2:0] PH_LEAD      = 3'd0;
  localparam logic [2:0] PH_SECT      = 3'd1;
  localparam logic [2:0] PH_SECT_DONE = 3'd2;
  localparam logic [2:0] PH_KEY       = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             overflowed, overflowed_next;
  logic             inside_quotes, inside_quotes_next;
  logic             content_cut, content_cut_next;
  logic [2:0]       parse_phase, parse_phase_next;
  logic [POS_W-1:0] name_start, name_start_next;
  logic [POS_W-1:0] name_end, name_end_next;
  logic [POS_W-1:0] value_start, value_start_next;
  logic [POS_W-1:0] value_end, value_end_next;
  logic             value_seen, value_seen_next;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind, kind_next;
  logic [OFS_W-1:0]  out_ns, out_ne, out_vs, out_ve;
  logic [POS_W-1:0]  ns_res, ne_res, vs_res, ve_res;

  logic             accept;
  logic [BYTE_W-1:0] c;
  logic             ws;
  logic [POS_W-1:0] pos_inc;

  assign c       = byte_stream.line_byte;
  assign ws      = is_ws(c);
  assign pos_inc = byte_position + POS_W'(1);

  // a last byte needs room in the output register, other bytes never wait
  assign byte_stream.ready = !out_valid || result.ready || !byte_stream.last_byte;
  assign accept = byte_stream.valid && byte_stream.ready;

  always_comb begin
    byte_position_next = byte_position;
    overflowed_next    = overflowed;
    inside_quotes_next = inside_quotes;
    content_cut_next   = content_cut;
    parse_phase_next   = parse_phase;
    name_start_next    = name_start;
    name_end_next      = name_end;
    value_start_next   = value_start;
    value_end_next     = value_end;
    value_seen_next    = value_seen;

    if (byte_position >= POS_W'(MAX_LINE)) begin
      overflowed_next = 1'b1;
    end else begin
      byte_position_next = pos_inc;
      if (!content_cut) begin
        if (c == CH_NUL) begin
          content_cut_next = 1'b1;
        end else if ((c == CH_SEMICOLON || c == CH_HASH) && !inside_quotes) begin
          content_cut_next = 1'b1;
        end else begin
          if (c == CH_QUOTE) begin
            inside_quotes_next = !inside_quotes;
          end
          case (parse_phase)
            PH_LEAD: begin
              if (!ws) begin
                if (c == CH_LBRACKET) begin
                  parse_phase_next = PH_SECT;
                end else if (c == CH_EQUALS) begin
                  parse_phase_next = PH_VALUE;
                end else begin
                  parse_phase_next = PH_KEY;
                  if (name_end == '0) name_start_next = byte_position;
                  name_end_next = pos_inc;
                end
              end
            end
            PH_SECT: begin
              if (c == CH_RBRACKET) begin
                parse_phase_next = PH_SECT_DONE;
              end else if (!ws) begin
                if (name_end == '0) name_start_next = byte_position;
                name_end_next = pos_inc;
              end
            end
            PH_KEY: begin
              if (c == CH_EQUALS) begin
                parse_phase_next = PH_VALUE;
              end else if (!ws) begin
                if (name_end == '0) name_start_next = byte_position;
                name_end_next = pos_inc;
              end
            end
            PH_VALUE: begin
              if (!ws) begin
                if (!value_seen) value_start_next = byte_position;
                value_end_next  = pos_inc;
                value_seen_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // classify the line from the state after its last byte
  always_comb begin
    ns_res = '0;
    ne_res = '0;
    vs_res = '0;
    ve_res = '0;
    if (overflowed_next) begin
      kind_next = KIND_TOO_LONG;
    end else begin
      case (parse_phase_next)
        PH_LEAD: kind_next = KIND_BLANK;
        PH_SECT_DONE: begin
          kind_next = KIND_SECTION;
          ns_res    = name_start_next;
          ne_res    = name_end_next;
        end
        PH_VALUE: begin
          kind_next = KIND_KEYVAL;
          ns_res    = name_start_next;
          ne_res    = name_end_next;
          if (value_seen_next) begin
            vs_res = value_start_next;
            ve_res = value_end_next;
          end
        end
        default: kind_next = KIND_IGNORED;
      endcase
      if (ne_res == '0) ns_res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      overflowed    <= 1'b0;
      inside_quotes <= 1'b0;
      content_cut   <= 1'b0;
      parse_phase   <= PH_LEAD;
      name_start    <= '0;
      name_end      <= '0;
      value_start   <= '0;
      value_end     <= '0;
      value_seen    <= 1'b0;
    end else if (accept) begin
      if (byte_stream.last_byte) begin
        byte_position <= '0;
        overflowed    <= 1'b0;
        inside_quotes <= 1'b0;
        content_cut   <= 1'b0;
        parse_phase   <= PH_LEAD;
        name_start    <= '0;
        name_end      <= '0;
        value_start   <= '0;
        value_end     <= '0;
        value_seen    <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        overflowed    <= overflowed_next;
        inside_quotes <= inside_quotes_next;
        content_cut   <= content_cut_next;
        parse_phase   <= parse_phase_next;
        name_start    <= name_start_next;
        name_end      <= name_end_next;
        value_start   <= value_start_next;
        value_end     <= value_end_next;
        value_seen    <= value_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && byte_stream.last_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_stream.last_byte) begin
      out_kind <= kind_next;
      out_ns   <= OFS_W'(ns_res);
      out_ne   <= OFS_W'(ne_res);
      out_vs   <= OFS_W'(vs_res);
      out_ve   <= OFS_W'(ve_res);
    end
  end

  assign result.valid       = out_valid;
  assign result.line_kind   = out_kind;
  assign result.name_start  = out_ns;
  assign result.name_end    = out_ne;
  assign result.value_start = out_vs;
  assign result.value_end   = out_ve;

endmodule

/* dv/tb_ini_line_tokenizer_core.sv */
`timescale 1ns / 1ps

module tb_ini_line_tokenizer_core;
  import ini_tok_pkg::*;

  localparam int unsigned LINE_MAX = MAX_LINE_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_SECT,
    SCAN_SECT_DONE,
    SCAN_KEY,
    SCAN_VALUE
  } scan_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFS_W-1:0]  name_start;
    logic [OFS_W-1:0]  name_end;
    logic [OFS_W-1:0]  value_start;
    logic [OFS_W-1:0]  value_end;
  } line_token_t;

  logic clk;
  logic rst;

  ini_tok_in_if  byte_if ();
  ini_tok_out_if token_if ();

  ini_line_tokenizer_core #(
    .MAX_LINE(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_stream(byte_if),
    .result(token_if)
  );

  line_token_t expected_tokens[$];
  int unsigned mismatches;
  int unsigned tokens_seen;
  int unsigned bytes_sent;
  int unsigned stall_cycles;
  bit          no_idle;

  // line tracker state
  int unsigned tr_pos;
  bit          tr_overflow;
  bit          tr_quoted;
  bit          tr_cut;
  scan_phase_t tr_phase;
  int unsigned tr_name_s;
  int unsigned tr_name_e;
  int unsigned tr_val_s;
  int unsigned tr_val_e;
  bit          tr_val_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit blank_char(logic [BYTE_W-1:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit special_char(logic [BYTE_W-1:0] c);
    return c == CH_NUL || c == CH_SEMICOLON || c == CH_HASH || c == CH_QUOTE ||
           c == CH_LBRACKET || c == CH_RBRACKET || c == CH_EQUALS;
  endfunction

  function void clear_tracker();
    tr_pos      = 0;
    tr_overflow = 1'b0;
    tr_quoted   = 1'b0;
    tr_cut      = 1'b0;
    tr_phase    = SCAN_LEAD;
    tr_name_s   = 0;
    tr_name_e   = 0;
    tr_val_s    = 0;
    tr_val_e    = 0;
    tr_val_seen = 1'b0;
  endfunction

  function void extend_name(int unsigned p);
    if (tr_name_e == 0) tr_name_s = p;
    tr_name_e = p + 1;
  endfunction

  function void scan_byte(logic [BYTE_W-1:0] c, int unsigned p);
    if (tr_cut) return;
    if (c == CH_NUL) begin
      tr_cut = 1'b1;
      return;
    end
    if (c == CH_QUOTE) begin
      tr_quoted = !tr_quoted;
    end else if ((c == CH_SEMICOLON || c == CH_HASH) && !tr_quoted) begin
      tr_cut = 1'b1;
      return;
    end
    case (tr_phase)
      SCAN_LEAD: begin
        if (!blank_char(c)) begin
          if (c == CH_LBRACKET) tr_phase = SCAN_SECT;
          else if (c == CH_EQUALS) tr_phase = SCAN_VALUE;
          else begin
            tr_phase = SCAN_KEY;
            extend_name(p);
          end
        end
      end
      SCAN_SECT: begin
        if (c == CH_RBRACKET) tr_phase = SCAN_SECT_DONE;
        else if (!blank_char(c)) extend_name(p);
      end
      SCAN_KEY: begin
        if (c == CH_EQUALS) tr_phase = SCAN_VALUE;
        else if (!blank_char(c)) extend_name(p);
      end
      SCAN_VALUE: begin
        if (!blank_char(c)) begin
          if (!tr_val_seen) tr_val_s = p;
          tr_val_e = p + 1;
          tr_val_seen = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function void predict_byte(logic [BYTE_W-1:0] c, bit last);
    line_token_t t;
    int unsigned ns, ne, vs, ve;
    if (tr_pos >= LINE_MAX) begin
      tr_overflow = 1'b1;
    end else begin
      scan_byte(c, tr_pos);
      tr_pos++;
    end
    if (!last) return;
    ns = 0;
    ne = 0;
    vs = 0;
    ve = 0;
    if (tr_overflow) begin
      t.kind = KIND_TOO_LONG;
    end else begin
      case (tr_phase)
        SCAN_LEAD: t.kind = KIND_BLANK;
        SCAN_SECT_DONE: begin
          t.kind = KIND_SECTION;
          ns = tr_name_s;
          ne = tr_name_e;
        end
        SCAN_VALUE: begin
          t.kind = KIND_KEYVAL;
          ns = tr_name_s;
          ne = tr_name_e;
          if (tr_val_seen) begin
            vs = tr_val_s;
            ve = tr_val_e;
          end
        end
        default: t.kind = KIND_IGNORED;
      endcase
      if (ne == 0) ns = 0;
    end
    t.name_start  = OFS_W'(ns);
    t.name_end    = OFS_W'(ne);
    t.value_start = OFS_W'(vs);
    t.value_end   = OFS_W'(ve);
    expected_tokens.push_back(t);
    clear_tracker();
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one; never with no_idle
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // entered and left at a falling edge; valid stays high after a transaction
  task automatic send_byte(logic [BYTE_W-1:0] c, bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid     = 1'b1;
    byte_if.line_byte = c;
    byte_if.last_byte = last;
    do @(posedge clk); while (!byte_if.ready);
    predict_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(string s);
    send_line(text_bytes(s));
  endtask

  task automatic wait_results_done();
    byte_if.valid = 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_ws();
    int unsigned r;
    r = $urandom_range(0, 6);
    return (r > 4) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_plain();
    logic [BYTE_W-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (special_char(c) || blank_char(c));
    return c;
  endfunction

  function automatic void add_ws(ref byte_q_t q, input int unsigned maxn);
    repeat ($urandom_range(0, maxn)) q.push_back(pick_ws());
  endfunction

  function automatic void add_word(ref byte_q_t q, input int unsigned n);
    repeat (n) q.push_back(($urandom_range(0, 7) == 0) ? pick_ws() : pick_plain());
  endfunction

  function automatic void add_mixed(ref byte_q_t q, input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        6: q.push_back(pick_ws());
        7: q.push_back(CH_EQUALS);
        8: q.push_back(CH_QUOTE);
        9: q.push_back($urandom_range(0, 1) ? CH_RBRACKET : CH_LBRACKET);
        default: q.push_back(pick_plain());
      endcase
    end
  endfunction

  function automatic void add_comment(ref byte_q_t q);
    q.push_back($urandom_range(0, 1) ? CH_SEMICOLON : CH_HASH);
    repeat ($urandom_range(0, 5)) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic byte_q_t build_random_line();
    byte_q_t q;
    case ($urandom_range(0, 19))
      0, 1: begin
        add_ws(q, 3);
        if ($urandom_range(0, 1)) add_comment(q);
      end
      2, 3, 4, 5: begin
        add_ws(q, 2);
        q.push_back(CH_LBRACKET);
        add_ws(q, 2);
        add_word(q, $urandom_range(0, 6));
        add_ws(q, 2);
        q.push_back(CH_RBRACKET);
        if ($urandom_range(0, 2) == 0) add_mixed(q, $urandom_range(1, 5));
        if ($urandom_range(0, 2) == 0) add_comment(q);
      end
      14, 15: begin
        case ($urandom_range(0, 3))
          0: begin
            q.push_back(CH_LBRACKET);
            add_word(q, $urandom_range(0, 6));
          end
          1: add_word(q, $urandom_range(1, 8));
          2: begin
            add_word(q, $urandom_range(0, 3));
            q.push_back(CH_NUL);
            q.push_back(CH_EQUALS);
            add_word(q, $urandom_range(0, 3));
          end
          default: begin
            add_word(q, $urandom_range(0, 3));
            if ($urandom_range(0, 1)) add_comment(q);
            q.push_back(CH_EQUALS);
            add_mixed(q, $urandom_range(0, 4));
          end
        endcase
      end
      16, 17: repeat ($urandom_range(1, 16)) q.push_back(8'($urandom_range(0, 255)));
      18, 19: begin
        add_ws(q, 2);
        add_word(q, $urandom_range(1, 4));
        q.push_back(CH_EQUALS);
        q.push_back(CH_QUOTE);
        add_word(q, $urandom_range(0, 3));
        q.push_back($urandom_range(0, 1) ? CH_SEMICOLON : CH_HASH);
        add_word(q, $urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) q.push_back(CH_QUOTE);
        add_ws(q, 2);
        if ($urandom_range(0, 1)) add_comment(q);
      end
      default: begin
        add_ws(q, 2);
        add_word(q, $urandom_range(0, 6));
        add_ws(q, 2);
        q.push_back(CH_EQUALS);
        add_ws(q, 2);
        add_mixed(q, $urandom_range(0, 8));
        add_ws(q, 2);
        if ($urandom_range(0, 2) == 0) add_comment(q);
      end
    endcase
    if (q.size() == 0) q.push_back(pick_ws());
    return q;
  endfunction

  task automatic test_blank_and_comment();
    send_text(" ");
    send_text("\011\012\013\014\015 ");
    send_text("; note");
    send_text("  # x = [y]");
    send_text("\010");
    send_text("\016");
  endtask

  task automatic test_sections();
    send_text("[core]");
    send_text(" [ a b ] tail = x");
    send_text("[]");
    send_text("[a\"]\"");
    send_text("[open");
    send_text("[x;]");
  endtask

  task automatic test_key_values();
    send_text("key = value");
    send_text("=v");
    send_text("k=");
    send_text("a = b = c ");
    send_text("\"k\" = \"v;#\" ; tail");
    send_text("\377\200=\177");
  endtask

  task automatic test_cut_and_broken();
    byte_q_t q;
    send_text("justtext");
    send_text("\"open ; = x");
    q = text_bytes("k");
    q.push_back(CH_NUL);
    q = {q, text_bytes("=v")};
    send_line(q);
    q.delete();
    q.push_back(CH_NUL);
    q = {q, text_bytes("[a]")};
    send_line(q);
  endtask

  task automatic test_line_length();
    byte_q_t q;
    int unsigned lens[3] = '{LINE_MAX, LINE_MAX + 1, LINE_MAX + 44};
    foreach (lens[i]) begin
      q = text_bytes("k=");
      while (q.size() < lens[i]) q.push_back(pick_plain());
      send_line(q);
    end
    send_text("[after]");
  endtask

  task automatic test_random_lines();
    byte_q_t q;
    int unsigned start;
    int unsigned long_left;
    int unsigned nlines;
    bit paused;
    start = bytes_sent;
    long_left = 3;
    nlines = 0;
    paused = 1'b0;
    while (bytes_sent < start + RANDOM_BYTES) begin
      if (nlines % 15 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (long_left != 0 && $urandom_range(0, 39) == 0) begin
        long_left--;
        q = text_bytes("key=");
        repeat ($urandom_range(LINE_MAX - 8, LINE_MAX + 40)) q.push_back(pick_plain());
      end else begin
        q = build_random_line();
      end
      send_line(q);
      nlines++;
      if (!paused && bytes_sent >= start + RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_results_done();
      end
    end
    no_idle = 1'b0;
  endtask

  // result side stalls with the same gap profile
  initial begin
    token_if.ready = 1'b0;
    forever begin
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
        token_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      token_if.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    line_token_t want;
    line_token_t got;
    if (!rst && token_if.valid && token_if.ready) begin
      got.kind        = token_if.line_kind;
      got.name_start  = token_if.name_start;
      got.name_end    = token_if.name_end;
      got.value_start = token_if.value_start;
      got.value_end   = token_if.value_end;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("token %0d: unexpected, kind %0d name %0d..%0d value %0d..%0d",
                   tokens_seen, got.kind, got.name_start, got.name_end,
                   got.value_start, got.value_end);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("token %0d: exp kind %0d name %0d..%0d value %0d..%0d",
                     tokens_seen, want.kind, want.name_start, want.name_end,
                     want.value_start, want.value_end);
            $display("token %0d: got kind %0d name %0d..%0d value %0d..%0d",
                     tokens_seen, got.kind, got.name_start, got.name_end,
                     got.value_start, got.value_end);
          end
        end
      end
      tokens_seen++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((byte_if.valid && byte_if.ready) || (token_if.valid && token_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ini_line_tokenizer_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.line_byte = '0;
    byte_if.last_byte = 1'b0;
    mismatches = 0;
    tokens_seen = 0;
    bytes_sent = 0;
    stall_cycles = 0;
    no_idle = 1'b0;
    clear_tracker();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_blank_and_comment();
    test_sections();
    wait_results_done();
    no_idle = 1'b1;
    test_key_values();
    no_idle = 1'b0;
    test_cut_and_broken();
    test_line_length();
    test_random_lines();

    wait_results_done();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("ini_line_tokenizer_core: match");
    end else begin
      $display("ini_line_tokenizer_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ini_tok_pkg.sv
rtl/ini_tok_if.sv
rtl/ini_line_tokenizer_core.sv
dv/tb_ini_line_tokenizer_core.sv
